@@ rtl/i6p_pkg.sv @@
// Shared types and constants of the IPv6 text address parser.
package i6p_pkg;

    localparam int MAX_LEN_DEF = 40;
    localparam int CCNT_W      = 6;
    localparam int NGROUPS     = 8;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LONG   = 2'd1;
    localparam logic [1:0] ST_SYNTAX = 2'd2;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEADCOLON,
        PH_DIGITS,
        PH_COLON,
        PH_GAP
    } t_phase;

    typedef struct packed {
        logic load;
        logic shift;
        logic gap;
        logic finish;
        logic syntax;
    } t_act;

    typedef struct packed {
        logic [NGROUPS-1:0][15:0] groups;
        logic                     gap_seen;
        logic [3:0]               gap_pos;
        logic [3:0]               group_count;
        logic [1:0]               status;
    } t_rec;

endpackage

@@ rtl/ipv6_text_address_parser.sv @@
// Top level of the IPv6 text address parser.
//
//   port group   dir  handshake               word
//   input        in   i_in_valid / o_in_stall  i_character, i_last
//   result       out  o_out_valid / i_out_stall o_address_high, o_address_low, o_status
//
// One character is taken per cycle while not stalled; the group state is registered.
// A finished record goes into the queue and from there into the output register.
// Results wait in a two-entry queue; the input stalls only when both entries are full.
// Reset is synchronous and clears all control state; the group store is not cleared.
module ipv6_text_address_parser import i6p_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [7:0]  i_character,
    input  logic        i_last,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [63:0] o_address_high,
    output logic [63:0] o_address_low,
    output logic [1:0]  o_status,
    input  logic        i_out_stall
);

    logic q_push, q_full, q_valid, q_pop;
    t_rec f_rec, q_rec;

    i6p_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_character (i_character),
        .i_last      (i_last),
        .o_stall     (o_in_stall),
        .o_push      (q_push),
        .o_rec       (f_rec),
        .i_full      (q_full)
    );

    i6p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (f_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec),
        .i_pop   (q_pop)
    );

    i6p_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_rec          (q_rec),
        .o_pop          (q_pop),
        .o_valid        (o_out_valid),
        .o_address_high (o_address_high),
        .o_address_low  (o_address_low),
        .o_status       (o_status),
        .i_stall        (i_out_stall)
    );

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |->
            ((o_address_high == 64'd0) && (o_address_low == 64'd0)))
        else $error("nonzero address with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_status == ST_OK) || (o_status == ST_LONG) || (o_status == ST_SYNTAX)))
        else $error("undefined status code");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("record pushed into full queue");

    a_gap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && (q_rec.status == ST_OK) && q_rec.gap_seen) |->
            (q_rec.gap_pos <= q_rec.group_count))
        else $error("gap beyond stored groups");

endmodule

@@ rtl/i6p_front.sv @@
// Character parser: tracks groups and the gap, emits one record per string.
module i6p_front import i6p_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_character,
    input  logic       i_last,
    output logic       o_stall,
    output logic       o_push,
    output t_rec       o_rec,
    input  logic       i_full
);

    t_phase                   r_phase, a_phase, n_phase;
    logic [3:0]               r_gc, n_gc;
    logic [3:0]               r_gpos, n_gpos;
    logic                     r_gap, n_gap;
    logic [15:0]              r_gv, n_gv;
    logic [2:0]               r_dc, n_dc;
    logic [NGROUPS-1:0][15:0] r_store, n_store;
    logic [CCNT_W-1:0]        r_cc, n_cc;
    logic [1:0]               r_err, n_err, err_a;

    t_act       act;
    logic       accept, long_now, active;
    logic       is_num, is_hex, is_colon;
    logic [3:0] digit;

    logic [NGROUPS-1:0][15:0] fin_store;
    logic [3:0]               fin_gc;
    logic [1:0]               fin_err;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    assign is_num   = (i_character >= CH_ZERO) && (i_character <= CH_NINE);
    assign is_hex   = is_num
                   || ((i_character >= CH_UPPER_A) && (i_character <= CH_UPPER_F))
                   || ((i_character >= CH_LOWER_A) && (i_character <= CH_LOWER_F));
    assign is_colon = (i_character == CH_COLON);
    assign digit    = is_num ? i_character[3:0] : i_character[3:0] + 4'd9;

    assign long_now = (r_cc >= CCNT_W'(MAX_LEN));
    assign err_a    = long_now ? ST_LONG : r_err;
    assign active   = (err_a == ST_OK);

    // next phase and per-character action
    always_comb begin
        a_phase = r_phase;
        act     = '0;
        if (is_hex) begin
            case (r_phase)
                PH_START, PH_COLON, PH_GAP: begin
                    act.load = 1'b1;
                    a_phase  = PH_DIGITS;
                end
                PH_DIGITS: begin
                    if (r_dc >= 3'd4) act.syntax = 1'b1;
                    else              act.shift  = 1'b1;
                end
                default: act.syntax = 1'b1;
            endcase
        end else if (is_colon) begin
            case (r_phase)
                PH_START: a_phase = PH_LEADCOLON;
                PH_LEADCOLON, PH_COLON: begin
                    if (r_gap) begin
                        act.syntax = 1'b1;
                    end else begin
                        act.gap = 1'b1;
                        a_phase = PH_GAP;
                    end
                end
                PH_DIGITS: begin
                    if (r_gc >= 4'd7) begin
                        act.syntax = 1'b1;
                    end else begin
                        act.finish = 1'b1;
                        a_phase    = PH_COLON;
                    end
                end
                default: act.syntax = 1'b1;
            endcase
        end else begin
            act.syntax = 1'b1;
        end
    end

    // datapath update
    always_comb begin
        n_phase = active ? a_phase : r_phase;
        n_err   = (active && act.syntax) ? ST_SYNTAX : err_a;
        n_cc    = long_now ? r_cc : r_cc + 1'b1;
        n_gv    = r_gv;
        n_dc    = r_dc;
        n_gc    = r_gc;
        n_gap   = r_gap;
        n_gpos  = r_gpos;
        n_store = r_store;
        if (active) begin
            if (act.load) begin
                n_gv = {12'd0, digit};
                n_dc = 3'd1;
            end
            if (act.shift) begin
                n_gv = {r_gv[11:0], digit};
                n_dc = r_dc + 3'd1;
            end
            if (act.gap) begin
                n_gap  = 1'b1;
                n_gpos = r_gc;
            end
            if (act.finish) begin
                n_store[r_gc[2:0]] = r_gv;
                n_gc = r_gc + 4'd1;
                n_gv = '0;
                n_dc = '0;
            end
        end
    end

    // end-of-string checks
    always_comb begin
        fin_store = n_store;
        fin_gc    = n_gc;
        fin_err   = n_err;
        if (fin_err == ST_OK) begin
            if (n_phase == PH_DIGITS) begin
                if (n_gc >= 4'd8) begin
                    fin_err = ST_SYNTAX;
                end else begin
                    fin_store[n_gc[2:0]] = n_gv;
                    fin_gc = n_gc + 4'd1;
                end
            end else if (n_phase != PH_GAP) begin
                fin_err = ST_SYNTAX;
            end
        end
        if (fin_err == ST_OK) begin
            if (n_gap ? (fin_gc > 4'd7) : (fin_gc != 4'd8)) fin_err = ST_SYNTAX;
        end
    end

    assign o_push            = accept && i_last;
    assign o_rec.groups      = fin_store;
    assign o_rec.gap_seen    = n_gap;
    assign o_rec.gap_pos     = n_gpos;
    assign o_rec.group_count = fin_gc;
    assign o_rec.status      = fin_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_gc    <= '0;
            r_gpos  <= '0;
            r_gap   <= 1'b0;
            r_gv    <= '0;
            r_dc    <= '0;
            r_cc    <= '0;
            r_err   <= ST_OK;
        end else if (accept) begin
            if (i_last) begin
                r_phase <= PH_START;
                r_gc    <= '0;
                r_gpos  <= '0;
                r_gap   <= 1'b0;
                r_gv    <= '0;
                r_dc    <= '0;
                r_cc    <= '0;
                r_err   <= ST_OK;
            end else begin
                r_phase <= n_phase;
                r_gc    <= n_gc;
                r_gpos  <= n_gpos;
                r_gap   <= n_gap;
                r_gv    <= n_gv;
                r_dc    <= n_dc;
                r_cc    <= n_cc;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_store <= n_store;
    end

endmodule

@@ rtl/i6p_queue.sv @@
// Two-entry record queue between parser and expander.
module i6p_queue import i6p_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    output logic o_valid,
    output t_rec o_rec,
    input  logic i_pop
);

    t_rec       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_rec;
    end

endmodule

@@ rtl/i6p_back.sv @@
// Gap expansion and registered result output.
module i6p_back import i6p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_rec        i_rec,
    output logic        o_pop,
    output logic        o_valid,
    output logic [63:0] o_address_high,
    output logic [63:0] o_address_low,
    output logic [1:0]  o_status,
    input  logic        i_stall
);

    logic                     r_valid;
    logic [63:0]              r_hi, r_lo;
    logic [1:0]               r_status;
    logic [NGROUPS-1:0][15:0] exp_g;
    logic [3:0]               zeros, src;
    logic                     load;

    assign load  = !r_valid || !i_stall;
    assign o_pop = i_valid && load;
    assign zeros = i_rec.gap_seen ? 4'd8 - i_rec.group_count : 4'd0;

    always_comb begin
        src = '0;
        for (int p = 0; p < NGROUPS; p++) begin
            src = 4'(p) - zeros;
            if (i_rec.status != ST_OK) begin
                exp_g[p] = '0;
            end else if (!i_rec.gap_seen || (4'(p) < i_rec.gap_pos)) begin
                exp_g[p] = i_rec.groups[p];
            end else if (4'(p) < i_rec.gap_pos + zeros) begin
                exp_g[p] = '0;
            end else begin
                exp_g[p] = i_rec.groups[src[2:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hi     <= {exp_g[0], exp_g[1], exp_g[2], exp_g[3]};
            r_lo     <= {exp_g[4], exp_g[5], exp_g[6], exp_g[7]};
            r_status <= i_rec.status;
        end
    end

    assign o_valid        = r_valid;
    assign o_address_high = r_hi;
    assign o_address_low  = r_lo;
    assign o_status       = r_status;

endmodule

@@ tb/ipv6_text_address_parser_test.sv @@
// Self-checking testbench of the IPv6 text address parser: directed and random strings.
module ipv6_text_address_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i6p_pkg::*;

    localparam int MAX_CHARS    = MAX_LEN_DEF;
    localparam int RANDOM_CHARS = 1400;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
        logic [1:0]  status;
    } t_parsed_addr;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_char   = 8'h00;
    logic        in_last   = 1'b0;
    logic        out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_address_high;
    logic [63:0] o_address_low;
    logic [1:0]  o_status;

    t_parsed_addr pending_addrs[$];
    logic [7:0]   line_buf[$];
    string        row_text[$];
    bit           row_typed[$];
    t_parsed_addr row_addr[$];
    bit           quiet = 1'b0;
    int           errors = 0;

    // parser state mirror
    t_phase              ph;
    logic [3:0]          n_groups;
    logic [3:0]          gap_at;
    logic                gap_taken;
    logic [15:0]         cur_group;
    logic [2:0]          n_digits;
    logic [15:0]         groups [NGROUPS];
    logic [CCNT_W-1:0]   n_chars;
    logic [1:0]          fault;

    ipv6_text_address_parser i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_character    (in_char),
        .i_last         (in_last),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_address_high (o_address_high),
        .o_address_low  (o_address_low),
        .o_status       (o_status),
        .i_out_stall    (out_stall)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1ms;
        $display("ipv6_text_address_parser_test: errors");
        $finish;
    end

    function automatic void clear_parser();
        ph        = PH_START;
        n_groups  = '0;
        gap_at    = '0;
        gap_taken = 1'b0;
        cur_group = '0;
        n_digits  = '0;
        n_chars   = '0;
        fault     = ST_OK;
        for (int g = 0; g < NGROUPS; g++) groups[g] = '0;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
        return -1;
    endfunction

    function automatic void mark_syntax();
        if (fault == ST_OK) fault = ST_SYNTAX;
    endfunction

    function automatic void close_group();
        if (n_groups >= 4'd8) begin
            mark_syntax();
        end else begin
            groups[n_groups[2:0]] = cur_group;
            n_groups++;
            cur_group = '0;
            n_digits  = '0;
        end
    endfunction

    function automatic void parse_char(logic [7:0] c);
        int d;
        d = hex_digit(c);
        if (d >= 0) begin
            case (ph)
                PH_START, PH_COLON, PH_GAP: begin
                    cur_group = 16'(d);
                    n_digits  = 3'd1;
                    ph        = PH_DIGITS;
                end
                PH_DIGITS: begin
                    if (n_digits >= 3'd4) begin
                        mark_syntax();
                    end else begin
                        cur_group = {cur_group[11:0], 4'(d)};
                        n_digits++;
                    end
                end
                default: mark_syntax();
            endcase
        end else if (c == CH_COLON) begin
            case (ph)
                PH_START: ph = PH_LEADCOLON;
                PH_LEADCOLON, PH_COLON: begin
                    if (gap_taken) begin
                        mark_syntax();
                    end else begin
                        gap_taken = 1'b1;
                        gap_at    = n_groups;
                        ph        = PH_GAP;
                    end
                end
                PH_DIGITS: begin
                    if (n_groups >= 4'd7) begin
                        mark_syntax();
                    end else begin
                        close_group();
                        ph = PH_COLON;
                    end
                end
                default: mark_syntax();
            endcase
        end else begin
            mark_syntax();
        end
    endfunction

    // Advances the mirror by one word; returns 1 with the address when the string ends.
    function automatic bit feed_char(input logic [7:0] c, input logic lst,
                                     output t_parsed_addr res);
        int unsigned zeros;
        logic [15:0] g;
        res = '0;
        if (n_chars >= MAX_CHARS) fault = ST_LONG;
        else n_chars++;
        if (fault == ST_OK) parse_char(c);
        if (!lst) return 1'b0;
        if (fault == ST_OK) begin
            if (ph == PH_DIGITS) close_group();
            else if (ph != PH_GAP) mark_syntax();
        end
        if (fault == ST_OK && (gap_taken ? n_groups > 4'd7 : n_groups != 4'd8)) mark_syntax();
        if (fault == ST_OK) begin
            zeros = gap_taken ? 8 - n_groups : 0;
            for (int p = 0; p < NGROUPS; p++) begin
                if (!gap_taken || p < gap_at) g = groups[p];
                else if (p < gap_at + zeros) g = '0;
                else g = groups[p - zeros];
                if (p < 4) res.high = {res.high[47:0], g};
                else res.low = {res.low[47:0], g};
            end
        end
        res.status = fault;
        clear_parser();
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] any_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10) return CH_ZERO + v;
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + v - 8'd10;
    endfunction

    function automatic logic [7:0] noise_char();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) return CH_COLON;
        if (r < 7) return any_hex_char();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_group();
        repeat ($urandom_range(1, 4)) line_buf.push_back(any_hex_char());
    endfunction

    function automatic void build_address();
        int unsigned n_explicit, split;
        line_buf.delete();
        if ($urandom_range(0, 2) == 0) begin
            for (int g = 0; g < NGROUPS; g++) begin
                if (g != 0) line_buf.push_back(CH_COLON);
                add_group();
            end
        end else begin
            n_explicit = $urandom_range(0, NGROUPS - 1);
            split      = $urandom_range(0, n_explicit);
            for (int g = 0; g < split; g++) begin
                if (g != 0) line_buf.push_back(CH_COLON);
                add_group();
            end
            line_buf.push_back(CH_COLON);
            line_buf.push_back(CH_COLON);
            for (int g = 0; g < n_explicit - split; g++) begin
                if (g != 0) line_buf.push_back(CH_COLON);
                add_group();
            end
        end
    endfunction

    function automatic void garble_line();
        int unsigned pos, target;
        pos = $urandom_range(0, line_buf.size() - 1);
        case ($urandom_range(0, 5))
            0: line_buf[pos] = 8'($urandom_range(0, 255));
            1: line_buf.insert(pos, CH_COLON);
            2: if (line_buf.size() > 1) line_buf.delete(pos);
            3: line_buf.push_back(any_hex_char());
            4: begin
                target = $urandom_range(MAX_CHARS + 1, 70);
                while (line_buf.size() < target) line_buf.push_back(noise_char());
            end
            default: begin
                line_buf.delete();
                repeat ($urandom_range(1, 12)) line_buf.push_back(noise_char());
            end
        endcase
    endfunction

    function automatic t_parsed_addr rejected(logic [1:0] st);
        return '{high: '0, low: '0, status: st};
    endfunction

    function automatic void add_row(string text, bit typed, t_parsed_addr a);
        row_text.push_back(text);
        row_typed.push_back(typed);
        row_addr.push_back(a);
    endfunction

    task automatic send_word(input logic [7:0] ch, input logic lst, input bit typed,
                             input t_parsed_addr typed_addr);
        int unsigned idle;
        t_parsed_addr got;
        idle = pick_gap();
        if (idle != 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= ch;
        in_last  <= lst;
        do @(posedge clk); while (o_in_stall);
        if (feed_char(ch, lst, got)) pending_addrs.push_back(typed ? typed_addr : got);
    endtask

    always begin : result_stall
        int unsigned hold;
        @(posedge clk);
        hold = pick_gap();
        if (hold == 0) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= 1'b1;
            repeat (hold - 1) @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_check
        t_parsed_addr want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_addrs.size() == 0) begin
                $error("result with none expected: high %h low %h status %0d",
                       o_address_high, o_address_low, o_status);
                errors++;
            end else begin
                want = pending_addrs.pop_front();
                if (o_address_high !== want.high) begin
                    $error("address_high: expected %h, got %h", want.high, o_address_high);
                    errors++;
                end
                if (o_address_low !== want.low) begin
                    $error("address_low: expected %h, got %h", want.low, o_address_low);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int r, i, sent;
        string txt;
        logic [7:0] ch;

        clear_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // '@' in a row stands for a NUL byte
        add_row("::", 1'b1, rejected(ST_OK));
        add_row("ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", 1'b1,
                '{high: 64'hffff_ffff_ffff_ffff, low: 64'hffff_ffff_ffff_ffff, status: ST_OK});
        add_row("0000:0000:0000:0000:0000:0000:0000:0000", 1'b1, rejected(ST_OK));
        add_row("1:2:3:4:5:6:7:8", 1'b1,
                '{high: 64'h0001_0002_0003_0004, low: 64'h0005_0006_0007_0008, status: ST_OK});
        add_row("1::", 1'b0, '0);
        add_row("::1", 1'b0, '0);
        add_row("12:3456::789a:bCdE", 1'b0, '0);
        add_row("1:2:3:4:5:6:7::", 1'b0, '0);
        add_row("1:2:3:4:5:6:7", 1'b1, rejected(ST_SYNTAX));
        add_row("1:2:3:4:5:6:7:8:9", 1'b1, rejected(ST_SYNTAX));
        add_row(":1:2:3:4:5:6:7:8", 1'b1, rejected(ST_SYNTAX));
        add_row(":::", 1'b1, rejected(ST_SYNTAX));
        add_row("1::2::3", 1'b1, rejected(ST_SYNTAX));
        add_row("1:2:3:4:5:6:7:", 1'b1, rejected(ST_SYNTAX));
        add_row("12345::", 1'b1, rejected(ST_SYNTAX));
        add_row("::ffff:1.2.3.4", 1'b1, rejected(ST_SYNTAX));
        add_row("::g", 1'b1, rejected(ST_SYNTAX));
        add_row("@::", 1'b1, rejected(ST_SYNTAX));
        add_row("\377::", 1'b1, rejected(ST_SYNTAX));
        add_row("g1:2:3:4:5:6:7:8", 1'b1, rejected(ST_SYNTAX));
        add_row("1", 1'b1, rejected(ST_SYNTAX));
        add_row(":", 1'b1, rejected(ST_SYNTAX));
        add_row("0000:0000:0000:0000:0000:0000:0000:0000::", 1'b1, rejected(ST_LONG));

        for (r = 0; r < row_text.size(); r++) begin
            txt = row_text[r];
            for (i = 0; i < txt.len(); i++) begin
                ch = (txt[i] == "@") ? 8'h00 : txt[i];
                send_word(ch, i == txt.len() - 1, row_typed[r], row_addr[r]);
            end
        end

        sent = 0;
        while (sent < RANDOM_CHARS) begin
            quiet = ($urandom_range(0, 5) == 0);
            build_address();
            if ($urandom_range(0, 4) == 0) garble_line();
            for (i = 0; i < line_buf.size(); i++)
                send_word(line_buf[i], i == line_buf.size() - 1, 1'b0, '0);
            sent += line_buf.size();
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_addrs.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("ipv6_text_address_parser_test: clean");
        end else begin
            $display("ipv6_text_address_parser_test: errors");
        end
        $finish;
    end

endmodule
